// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the queue and back RTL files.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define BCDTP_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define BCDTP_ASSERT_NXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- rtl/core/bcdtp_pkg.sv -----
// ----------------------------------------------------------------------------
// bcdtp_pkg
// Types and constants shared by the time frame parser front, queue and back.
// ----------------------------------------------------------------------------
package bcdtp_pkg;

  // Frame bytes
  localparam logic [7:0] CMD_TIME  = 8'h01;
  localparam logic [7:0] CMD_ALARM = 8'h02;
  localparam logic [7:0] TRAILER   = 8'hAA;

  // Result status codes
  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_TIME_OK  = 2'd1;
  localparam logic [1:0] ST_ALARM_OK = 2'd2;
  localparam logic [1:0] ST_REJECT   = 2'd3;

  // Entries in the job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Position within a five-byte frame
  typedef enum logic [2:0] {
    POS_HUNT,
    POS_PAY0,
    POS_PAY1,
    POS_PAY2,
    POS_TRAIL
  } pos_t;

  // One classified request handed from front to back
  typedef struct packed {
    logic            is_trailer;  // this byte closed a frame
    logic            is_alarm;    // frame was a set-alarm frame
    logic            trailer_ok;  // closing byte was the trailer
    logic [2:0][7:0] payload;     // stored payload, index 0 first
  } job_t;

  // One result
  typedef struct packed {
    logic [1:0] frame_status;
    logic       send_ack;
    logic [4:0] hour_out;
    logic [5:0] minute_out;
    logic [5:0] second_out;
    logic [2:0] alarm_slot;
  } res_t;

endpackage

// ----- rtl/core/bcdtp_ifs.sv -----
// ----------------------------------------------------------------------------
// bcdtp_ifs
// Valid/ready channels of the parser: received bytes in, results out.
// ----------------------------------------------------------------------------
interface bcdtp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bcdtp_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_status;
  logic       send_ack;
  logic [4:0] hour_out;
  logic [5:0] minute_out;
  logic [5:0] second_out;
  logic [2:0] alarm_slot;

  modport source (output valid, output frame_status, output send_ack, output hour_out,
                  output minute_out, output second_out, output alarm_slot, input ready);
  modport sink   (input valid, input frame_status, input send_ack, input hour_out,
                  input minute_out, input second_out, input alarm_slot, output ready);
endinterface

// ----- rtl/core/bcdtp_front.sv -----
// ----------------------------------------------------------------------------
// bcdtp_front
// Tracks frame position, stores payload bytes and turns every received byte
// into one job for the back end.
// ----------------------------------------------------------------------------
module bcdtp_front
  import bcdtp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  bcdtp_rx_if.sink rx,
  output logic push,
  output job_t job,
  input  logic q_full
);

  pos_t            pos, pos_next;
  logic            is_alarm, is_alarm_next;
  logic [2:0][7:0] payload;
  logic            take;

  assign rx.ready = !q_full;
  assign take     = rx.valid && !q_full;
  assign push     = take;

  // Position and command registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= POS_HUNT;
      is_alarm <= 1'b0;
    end else begin
      pos      <= pos_next;
      is_alarm <= is_alarm_next;
    end
  end

  // Payload storage, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      case (pos)
        POS_PAY0: payload[0] <= rx.rx_byte;
        POS_PAY1: payload[1] <= rx.rx_byte;
        POS_PAY2: payload[2] <= rx.rx_byte;
        default: ;
      endcase
    end
  end

  // Next position and job classification
  always_comb begin
    pos_next       = pos;
    is_alarm_next  = is_alarm;
    job.is_trailer = 1'b0;
    job.is_alarm   = is_alarm;
    job.trailer_ok = (rx.rx_byte == TRAILER);
    job.payload    = payload;
    case (pos)
      POS_HUNT: begin
        if (take && (rx.rx_byte == CMD_TIME || rx.rx_byte == CMD_ALARM)) begin
          is_alarm_next = (rx.rx_byte == CMD_ALARM);
          pos_next      = POS_PAY0;
        end
      end
      POS_PAY0: if (take) pos_next = POS_PAY1;
      POS_PAY1: if (take) pos_next = POS_PAY2;
      POS_PAY2: if (take) pos_next = POS_TRAIL;
      POS_TRAIL: begin
        job.is_trailer = 1'b1;
        if (take) pos_next = POS_HUNT;
      end
      default: pos_next = POS_HUNT;
    endcase
  end

endmodule

// ----- rtl/core/bcdtp_queue.sv -----
// ----------------------------------------------------------------------------
// bcdtp_queue
// Short job queue that lets the front and back stall independently.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bcdtp_queue
  import bcdtp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `BCDTP_ASSERT_IMP(a_no_overflow, push, !full, "queue push while full")
  `BCDTP_ASSERT_IMP(a_no_underflow, pop, !empty, "queue pop while empty")
  `BCDTP_ASSERT_IMP(a_count_range, 1'b1, count <= CNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

// ----- rtl/core/bcdtp_back.sv -----
// ----------------------------------------------------------------------------
// bcdtp_back
// Judges closed frames (BCD range checks, slot check) and holds the result
// in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bcdtp_back
  import bcdtp_pkg::*;
#(
  parameter int ALARM_SLOTS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  job_t head,
  output logic pop,
  bcdtp_res_if.source res
);

  logic res_valid;
  res_t res_q, res_d;
  logic [6:0] val0, val1, val2;
  logic ok0, ok1, ok2;
  logic [7:0] slot_n;
  logic [7:0] slot_m1;

  function automatic logic bcd_ok(input logic [7:0] b);
    bcd_ok = (b[3:0] <= 4'd9) && (b[7:4] <= 4'd9);
  endfunction

  // tens * 10 + units, as shifts and adds
  function automatic logic [6:0] bcd_val(input logic [7:0] b);
    bcd_val = {b[7:4], 3'b000} + {2'b00, b[7:4], 1'b0} + {3'b000, b[3:0]};
  endfunction

  assign pop = !q_empty && (!res_valid || res.ready);

  // Frame judgement
  always_comb begin
    ok0     = bcd_ok(head.payload[0]);
    ok1     = bcd_ok(head.payload[1]);
    ok2     = bcd_ok(head.payload[2]);
    val0    = bcd_val(head.payload[0]);
    val1    = bcd_val(head.payload[1]);
    val2    = bcd_val(head.payload[2]);
    slot_n  = head.payload[0];
    slot_m1 = slot_n - 8'd1;
    res_d   = '0;
    if (head.is_trailer) begin
      res_d.frame_status = ST_REJECT;
      if (head.trailer_ok && !head.is_alarm) begin
        if (ok0 && ok1 && ok2 && val0 < 7'd24 && val1 < 7'd60 && val2 < 7'd60) begin
          res_d.frame_status = ST_TIME_OK;
          res_d.send_ack     = 1'b1;
          res_d.hour_out     = val0[4:0];
          res_d.minute_out   = val1[5:0];
          res_d.second_out   = val2[5:0];
        end
      end else if (head.trailer_ok && head.is_alarm) begin
        if (slot_n != 8'd0 && slot_n <= 8'(ALARM_SLOTS) && ok1 && ok2 &&
            val1 < 7'd24 && val2 < 7'd60) begin
          res_d.frame_status = ST_ALARM_OK;
          res_d.send_ack     = 1'b1;
          res_d.hour_out     = val1[4:0];
          res_d.minute_out   = val2[5:0];
          res_d.alarm_slot   = slot_m1[2:0];
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) res_q <= res_d;
  end

  assign res.valid        = res_valid;
  assign res.frame_status = res_q.frame_status;
  assign res.send_ack     = res_q.send_ack;
  assign res.hour_out     = res_q.hour_out;
  assign res.minute_out   = res_q.minute_out;
  assign res.second_out   = res_q.second_out;
  assign res.alarm_slot   = res_q.alarm_slot;

  `BCDTP_ASSERT_IMP(a_ack_match, res_valid,
    res_q.send_ack == (res_q.frame_status == ST_TIME_OK || res_q.frame_status == ST_ALARM_OK),
    "ack flag disagrees with status")
  `BCDTP_ASSERT_IMP(a_reject_zero, res_valid && !res_q.send_ack,
    res_q.hour_out == '0 && res_q.minute_out == '0 && res_q.alarm_slot == '0,
    "fields not cleared on rejected or idle result")
  `BCDTP_ASSERT_NXT(a_pop_loads, pop, res_valid, "popped job did not reach output")

endmodule

// ----- rtl/core/bcd_time_frame_parser_unit.sv -----
// ----------------------------------------------------------------------------
// bcd_time_frame_parser_unit
// Five-byte set-time / set-alarm frame parser with one result per byte.
// ----------------------------------------------------------------------------
// Usage:
//   rx  : valid/ready channel of received bytes (rx_byte).
//   res : valid/ready channel of results, exactly one per accepted byte:
//         frame_status, send_ack, hour_out, minute_out, second_out, alarm_slot.
//   A byte is taken on a clock edge with valid and ready both high.
//   Throughput: one byte per cycle sustained while the receiver keeps up.
//   An accepted byte is written into the queue, then popped into the output
//   register, where its result becomes valid.
//   The front tracks frame position and payload; a two-entry job queue feeds
//   the back, which checks BCD ranges and the alarm slot combinationally.
//   Stall: if res.ready is low the result holds; up to two more bytes are
//   queued, then rx.ready drops until the receiver takes a result.
//   Reset (rst, synchronous): position returns to hunting for a command,
//   queue and output register empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
module bcd_time_frame_parser_unit
  import bcdtp_pkg::*;
#(
  parameter int ALARM_SLOTS = 8
) (
  input  logic clk,
  input  logic rst,
  bcdtp_rx_if.sink    rx,
  bcdtp_res_if.source res
);

  logic push, pop, q_full, q_empty;
  job_t push_job, head;

  // Frame tracking and classification
  bcdtp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .push   (push),
    .job    (push_job),
    .q_full (q_full)
  );

  // Job queue
  bcdtp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  // Judge and output register
  bcdtp_back #(
    .ALARM_SLOTS (ALARM_SLOTS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .res     (res)
  );

endmodule
